[design/ocs_pkg.sv]
// Package for the overlap chunk stitcher: command codes, field widths and
// default sizes shared by the top level and the divider.
// No dependencies.
package ocs_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_MOVE   = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   // Chunk progress codes.
   localparam logic [1:0] SEEN_NONE  = 2'd0;
   localparam logic [1:0] SEEN_FIRST = 2'd1;
   localparam logic [1:0] SEEN_LATER = 2'd2;

   localparam int HOLD_DEPTH_DEFAULT = 64;

   // One held element: move flag, base and quality.
   localparam int ENTRY_W = 17;

   // Field widths.
   localparam int RAW_W    = 16;
   localparam int OFFSET_W = 32;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 16;
   localparam int SKIP_W   = 7;
   localparam logic [SKIP_W-1:0] SKIP_MAX = 7'd127;

   // Stream widths.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // Shared divider: dividend covers the overlap, divisor covers a move count.
   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = 6;

endpackage

[design/overlap_chunk_stitcher.sv]
// Top level of the overlap chunk stitcher: sequencer, holdback ring and
// output register. Depends on ocs_pkg, ocs_ram and ocs_divider.
//
// The block joins the overlapping chunks of one read into a single stream of
// move flags, bases and qualities. A header item opens a chunk, move items
// follow, and a flush item ends the read. The last HOLD_DEPTH kept elements
// of a chunk sit in a ring buffer so that the next header can trim the rear
// half of the overlap from them; the front half is skipped at the head of the
// new chunk. A move item that finds the ring full first releases the oldest
// element (plus any wait on rsp_tready). A header that opens a read goes from
// its accept straight to closing the header. A later header runs the shared
// one-bit-per-cycle divider for the stride on the second header only, when
// the first chunk had elements, and for the overlap whenever it is positive
// and the stride is nonzero, then trims, releases the kept elements and
// closes the header. Each released element costs a read of the holdback RAM
// and a load of the output register. A flush releases every held element and
// then ends the read. The input is not ready while an item is in progress; a
// result waits in its own output register.
module overlap_chunk_stitcher #(
   parameter int HOLD_DEPTH = ocs_pkg::HOLD_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // From bit 0: raw_size[15:0], chunk_offset[31:0], move_bit, base_char[7:0],
   // qual_char[7:0], then zero padding.
   input  logic [ocs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // From bit 0: cmd[1:0].
   input  logic [ocs_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // From bit 0: out_move, out_base[7:0], out_qual[7:0], then zero padding.
   output logic [ocs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // run_end: last result caused by the input item.
   output logic                            rsp_tlast,
   // From bit 0: read_end, overflow.
   output logic [ocs_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int AW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CW  = $clog2(HOLD_DEPTH + 1);
   localparam int EW  = ocs_pkg::ENTRY_W;
   localparam int RW  = ocs_pkg::RAW_W;
   localparam int OW  = ocs_pkg::OFFSET_W;
   localparam int XW  = ocs_pkg::INDEX_W;
   localparam int SW  = ocs_pkg::SKIP_W;
   localparam int DW  = ocs_pkg::DIVIDEND_W;
   localparam int VW  = ocs_pkg::DIVISOR_W;
   localparam int CHW = ocs_pkg::CHAR_W;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_ELEM_OUT  = 4'd1;
   localparam logic [3:0] ST_STRIDE    = 4'd2;
   localparam logic [3:0] ST_STRIDE_WT = 4'd3;
   localparam logic [3:0] ST_OVL       = 4'd4;
   localparam logic [3:0] ST_OVL_WT    = 4'd5;
   localparam logic [3:0] ST_TRIM      = 4'd6;
   localparam logic [3:0] ST_DRAIN_RD  = 4'd7;
   localparam logic [3:0] ST_DRAIN_OUT = 4'd8;
   localparam logic [3:0] ST_HDR_END   = 4'd9;
   localparam logic [3:0] ST_FLUSH_END = 4'd10;

   // Input field slices.
   logic [1:0]     f_cmd;
   logic [RW-1:0]  f_raw;
   logic [OW-1:0]  f_off;
   logic           f_move;
   logic [CHW-1:0] f_base;
   logic [CHW-1:0] f_qual;
   logic [EW-1:0]  f_entry;

   assign f_cmd   = req_tuser[1:0];
   assign f_raw   = req_tdata[RW-1:0];
   assign f_off   = req_tdata[RW+OW-1:RW];
   assign f_move  = req_tdata[RW+OW];
   assign f_base  = req_tdata[RW+OW+CHW:RW+OW+1];
   assign f_qual  = req_tdata[RW+OW+2*CHW:RW+OW+CHW+1];
   assign f_entry = f_move ? {1'b1, f_base, f_qual} : '0;

   // Control state.
   logic [3:0]     state_ff, state_in;
   logic [1:0]     seen_ff, seen_in;
   logic [CW-1:0]  held_ff, held_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [XW-1:0]  index_ff, index_in;
   logic [SW-1:0]  skip_ff, skip_in;
   logic [RW-1:0]  prior_raw_ff, prior_raw_in;
   logic [OW:0]    prior_end_ff, prior_end_in;
   logic [XW-1:0]  moves_ff, moves_in;
   logic [VW-1:0]  stride_ff, stride_in;
   logic           ovf_ff, ovf_in;
   logic           flush_ff, flush_in;
   logic [CW-1:0]  keep_ff, keep_in;
   logic [CW-1:0]  drain_ff, drain_in;

   // Payload held across the header sequence.
   logic [RW-1:0]  hdr_raw_ff, hdr_raw_in;
   logic [OW-1:0]  hdr_off_ff, hdr_off_in;
   logic [EW-1:0]  elem_ff, elem_in;
   logic [DW-1:0]  od_ff, od_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]  rsp_entry_ff, rsp_entry_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_rend_ff, rsp_rend_in;
   logic           rsp_ovf_ff, rsp_ovf_in;
   logic           out_free;

   // Holdback RAM and divider hookup.
   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]  ram_wr_data, ram_rd_data;
   logic           div_start, div_done;
   logic [DW-1:0]  div_dividend, div_quotient;
   logic [VW-1:0]  div_divisor;

   // Overlap and trim arithmetic.
   logic [OW+1:0]  ovl_diff;
   logic [DW-2:0]  rear;
   logic [DW-1:0]  front;
   logic [XW:0]    stride_num;
   logic           accept;
   logic           drain_last;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW + 1)'(HOLD_DEPTH)) begin
         sum = sum - (AW + 1)'(HOLD_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ovl_diff   = {1'b0, prior_end_ff} - {2'b0, hdr_off_ff};
   assign rear       = od_ff[DW-1:1];
   assign front      = {1'b0, od_ff[DW-1:1]} + {{(DW - 1){1'b0}}, od_ff[0]};
   assign stride_num = {1'b0, prior_raw_ff} + {2'b0, moves_ff[XW-1:1]};
   assign drain_last = (drain_ff + 1'b1) == keep_ff;

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      held_in      = held_ff;
      head_in      = head_ff;
      index_in     = index_ff;
      skip_in      = skip_ff;
      prior_raw_in = prior_raw_ff;
      prior_end_in = prior_end_ff;
      moves_in     = moves_ff;
      stride_in    = stride_ff;
      ovf_in       = ovf_ff;
      flush_in     = flush_ff;
      keep_in      = keep_ff;
      drain_in     = drain_ff;
      hdr_raw_in   = hdr_raw_ff;
      hdr_off_in   = hdr_off_ff;
      elem_in      = elem_ff;
      od_in        = od_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_rend_in  = rsp_rend_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ring_add(head_ff, held_ff[AW-1:0]);
      ram_wr_data  = f_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ring_add(head_ff, drain_ff[AW-1:0]);
      div_start    = 1'b0;
      div_dividend = {{(DW - XW - 1){1'b0}}, stride_num};
      div_divisor  = moves_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (f_cmd)
                  ocs_pkg::CMD_MOVE: begin
                     if (seen_ff != ocs_pkg::SEEN_NONE) begin
                        if (index_ff != '1) begin
                           index_in = index_ff + 1'b1;
                        end
                        if (seen_ff == ocs_pkg::SEEN_FIRST) begin
                           moves_in = index_in;
                        end
                        // Elements inside the front half of the overlap are skipped.
                        if (index_ff >= {{(XW - SW){1'b0}}, skip_ff}) begin
                           if (held_ff == CW'(HOLD_DEPTH)) begin
                              // Ring full: release the oldest element first.
                              ram_rd_en   = 1'b1;
                              ram_rd_addr = head_ff;
                              elem_in     = f_entry;
                              state_in    = ST_ELEM_OUT;
                           end else begin
                              ram_wr_en = 1'b1;
                              held_in   = held_ff + 1'b1;
                           end
                        end
                     end
                  end
                  ocs_pkg::CMD_HEADER: begin
                     hdr_raw_in = f_raw;
                     hdr_off_in = f_off;
                     flush_in   = 1'b0;
                     unique case (seen_ff)
                        ocs_pkg::SEEN_NONE:  state_in = ST_HDR_END;
                        ocs_pkg::SEEN_FIRST: state_in = ST_STRIDE;
                        default:             state_in = ST_OVL;
                     endcase
                  end
                  ocs_pkg::CMD_FLUSH: begin
                     flush_in = 1'b1;
                     keep_in  = held_ff;
                     drain_in = '0;
                     if (seen_ff != ocs_pkg::SEEN_NONE && held_ff != '0) begin
                        state_in = ST_DRAIN_RD;
                     end else begin
                        state_in = ST_FLUSH_END;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ELEM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = ram_rd_data;
               rsp_last_in  = 1'b1;
               rsp_rend_in  = 1'b0;
               rsp_ovf_in   = ovf_ff;
               ram_wr_en    = 1'b1;
               ram_wr_addr  = head_ff;
               ram_wr_data  = elem_ff;
               head_in      = ring_add(head_ff, AW'(1));
               state_in     = ST_IDLE;
            end
         end

         ST_STRIDE: begin
            // Stride is the rounded quotient of the first chunk's raw size
            // by its element count.
            if (moves_ff != '0) begin
               div_start = 1'b1;
               state_in  = ST_STRIDE_WT;
            end else begin
               stride_in = '0;
               state_in  = ST_OVL;
            end
         end

         ST_STRIDE_WT: begin
            if (div_done) begin
               stride_in = div_quotient[VW-1:0];
               state_in  = ST_OVL;
            end
         end

         ST_OVL: begin
            // A negative or zero overlap, or a zero stride, trims nothing.
            div_dividend = ovl_diff[DW-1:0];
            div_divisor  = stride_ff;
            if (!ovl_diff[OW+1] && ovl_diff != '0 && stride_ff != '0) begin
               div_start = 1'b1;
               state_in  = ST_OVL_WT;
            end else begin
               od_in    = '0;
               state_in = ST_TRIM;
            end
         end

         ST_OVL_WT: begin
            if (div_done) begin
               od_in    = div_quotient;
               state_in = ST_TRIM;
            end
         end

         ST_TRIM: begin
            drain_in = '0;
            if (rear > {{(DW - 1 - CW){1'b0}}, held_ff}) begin
               ovf_in  = 1'b1;
               keep_in = '0;
            end else begin
               keep_in = held_ff - rear[CW-1:0];
            end
            if (front > {{(DW - SW){1'b0}}, ocs_pkg::SKIP_MAX}) begin
               skip_in = ocs_pkg::SKIP_MAX;
            end else begin
               skip_in = front[SW-1:0];
            end
            if (keep_in == '0) begin
               state_in = ST_HDR_END;
            end else begin
               state_in = ST_DRAIN_RD;
            end
         end

         ST_DRAIN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_DRAIN_OUT;
         end

         ST_DRAIN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = ram_rd_data;
               rsp_last_in  = drain_last;
               rsp_rend_in  = drain_last && flush_ff;
               rsp_ovf_in   = ovf_ff;
               if (drain_last) begin
                  state_in = flush_ff ? ST_FLUSH_END : ST_HDR_END;
               end else begin
                  drain_in = drain_ff + 1'b1;
                  state_in = ST_DRAIN_RD;
               end
            end
         end

         ST_HDR_END: begin
            if (seen_ff == ocs_pkg::SEEN_NONE) begin
               seen_in  = ocs_pkg::SEEN_FIRST;
               skip_in  = '0;
               moves_in = '0;
            end else begin
               seen_in = ocs_pkg::SEEN_LATER;
            end
            prior_raw_in = hdr_raw_ff;
            prior_end_in = {1'b0, hdr_off_ff} + {{(OW + 1 - RW){1'b0}}, hdr_raw_ff};
            index_in     = '0;
            held_in      = '0;
            head_in      = '0;
            state_in     = ST_IDLE;
         end

         ST_FLUSH_END: begin
            // End of read: all read state but flush_ff, keep_ff and drain_ff is reset.
            seen_in      = ocs_pkg::SEEN_NONE;
            held_in      = '0;
            head_in      = '0;
            index_in     = '0;
            skip_in      = '0;
            prior_raw_in = '0;
            prior_end_in = '0;
            moves_in     = '0;
            stride_in    = '0;
            ovf_in       = 1'b0;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= ocs_pkg::SEEN_NONE;
         held_ff      <= '0;
         head_ff      <= '0;
         index_ff     <= '0;
         skip_ff      <= '0;
         prior_raw_ff <= '0;
         prior_end_ff <= '0;
         moves_ff     <= '0;
         stride_ff    <= '0;
         ovf_ff       <= 1'b0;
         flush_ff     <= 1'b0;
         keep_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         held_ff      <= held_in;
         head_ff      <= head_in;
         index_ff     <= index_in;
         skip_ff      <= skip_in;
         prior_raw_ff <= prior_raw_in;
         prior_end_ff <= prior_end_in;
         moves_ff     <= moves_in;
         stride_ff    <= stride_in;
         ovf_ff       <= ovf_in;
         flush_ff     <= flush_in;
         keep_ff      <= keep_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_raw_ff   <= hdr_raw_in;
      hdr_off_ff   <= hdr_off_in;
      elem_ff      <= elem_in;
      od_ff        <= od_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rend_ff  <= rsp_rend_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   ocs_ram #(
      .WIDTH (EW),
      .DEPTH (HOLD_DEPTH),
      .AW    (AW)
   ) u_holdback (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ocs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ocs_pkg::RSP_DATA_W - EW){1'b0}},
                        rsp_entry_ff[CHW-1:0], rsp_entry_ff[2*CHW-1:CHW], rsp_entry_ff[EW-1]};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_rend_ff};

endmodule

[design/ocs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used as the holdback store of the overlap chunk stitcher. No dependencies.
module ocs_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ocs_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by the stride and
// overlap computations of the overlap chunk stitcher. Depends on ocs_pkg.
module ocs_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ocs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [ocs_pkg::DIVISOR_W-1:0]  divisor,
   output logic                          done,
   output logic [ocs_pkg::DIVIDEND_W-1:0] quotient
);

   localparam int DW = ocs_pkg::DIVIDEND_W;
   localparam int VW = ocs_pkg::DIVISOR_W;
   localparam int CW = ocs_pkg::DIV_CNT_W;

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits VW bits.
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[tb/sv/overlap_chunk_stitcher_tb.sv]
// Self-checking testbench for overlap_chunk_stitcher: streams chunk headers, move
// elements and flushes, predicts the stitched output and compares it item by item.
// Depends on ocs_pkg and the overlap_chunk_stitcher top level.
module overlap_chunk_stitcher_tb;

   localparam int HOLD = ocs_pkg::HOLD_DEPTH_DEFAULT;
   // The unused command code; the block must ignore it.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int unsigned INDEX_MAX = (1 << ocs_pkg::INDEX_W) - 1;
   // Once this few items remain to be sent, neither side idles any more.
   localparam int TAIL_ITEMS = 60;
   // Cycles to wait after the last expected result; covers a full header or flush.
   localparam int SETTLE_CYCLES = 300;
   // The long chunk overruns the holdback ring.
   localparam int LONG_CHUNK_MOVES = 70;

   // One element as it sits in the holdback buffer.
   typedef struct packed {
      logic                      mv;
      logic [ocs_pkg::CHAR_W-1:0] base;
      logic [ocs_pkg::CHAR_W-1:0] qual;
   } held_elem_type;

   // One element of the stitched read as it should leave the block.
   typedef struct {
      held_elem_type elem;
      bit            run_end;
      bit            read_end;
      bit            ovf;
   } stitched_elem_type;

   // One request item waiting to be sent.
   typedef struct {
      logic [1:0]                     cmd;
      logic [ocs_pkg::REQ_DATA_W-1:0] data;
      int                             gap_pct;
      bit                             wait_drain;
   } send_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ocs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ocs_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ocs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic [ocs_pkg::RSP_USER_W-1:0] rsp_tuser;

   overlap_chunk_stitcher #(.HOLD_DEPTH(HOLD)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Items still to be sent, and the stitched elements the block still owes us.
   send_item_type     send_queue[$];
   stitched_elem_type expected_elems[$];

   // Our own copy of the stitcher state. The holdback buffer is a queue whose
   // size is the number of held elements.
   held_elem_type held_elems[$];
   int unsigned   elem_index = 0;
   int unsigned   head_skip = 0;
   int unsigned   prior_raw = 0;
   longint        prior_off = 0;
   int unsigned   first_moves = 0;
   int unsigned   stride = 0;
   logic [1:0]    chunk_seen = ocs_pkg::SEEN_NONE;
   bit            overflow_sticky = 1'b0;

   // Counters for the summary and the verdict.
   int mismatches = 0;
   int results_checked = 0;
   int overflow_results = 0;
   int ring_releases = 0;
   int headers_sent = 0;
   int moves_sent = 0;
   int flushes_sent = 0;
   int spare_sent = 0;
   int stim_items = 0;
   int cur_gap_pct = 0;

   // Driver and receiver bookkeeping.
   send_item_type offered;
   bit            offer;
   bit            gap_done = 1'b0;
   int            send_gap_left = 0;
   int            stall_left = 0;
   int            recv_pct = 0;
   int            cycle_count = 0;

   function automatic int pick_gap_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   // Lays out the request fields from bit 0 up; the padding bits stay zero.
   function automatic logic [ocs_pkg::REQ_DATA_W-1:0] pack_fields(
         input logic [ocs_pkg::RAW_W-1:0] raw, input logic [ocs_pkg::OFFSET_W-1:0] off,
         input logic mv, input logic [ocs_pkg::CHAR_W-1:0] base,
         input logic [ocs_pkg::CHAR_W-1:0] qual);
      logic [ocs_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[15:0]  = raw;
      d[47:16] = off;
      d[48]    = mv;
      d[56:49] = base;
      d[64:57] = qual;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
               results_checked, what, got, want);
   endtask

   task automatic release_elem(input held_elem_type e, input bit run_end, input bit read_end);
      stitched_elem_type r;
      r.elem     = e;
      r.run_end  = run_end;
      r.read_end = read_end;
      r.ovf      = overflow_sticky;
      expected_elems.insert(expected_elems.size(), r);
   endtask

   // Works out what one accepted item does to the stitcher and which elements
   // it releases, in order.
   task automatic stitch_item(input send_item_type it);
      logic [ocs_pkg::RAW_W-1:0]    raw;
      logic [ocs_pkg::OFFSET_W-1:0] off;
      held_elem_type                e;
      int unsigned                  idx;
      longint                       ov, od, rear, front, keep;
      raw = it.data[15:0];
      off = it.data[47:16];
      case (it.cmd)
         ocs_pkg::CMD_MOVE: begin
            moves_sent++;
            if (chunk_seen == ocs_pkg::SEEN_NONE)
               return;
            idx = elem_index;
            if (elem_index < INDEX_MAX)
               elem_index++;
            if (chunk_seen == ocs_pkg::SEEN_FIRST)
               first_moves = elem_index;
            // Elements in the front half of the overlap are dropped outright.
            if (idx < head_skip)
               return;
            e = '0;
            if (it.data[48])
               e = {1'b1, it.data[56:49], it.data[64:57]};
            // A full buffer pushes its oldest element out to make room.
            if (held_elems.size() >= HOLD) begin
               release_elem(held_elems.pop_front(), 1'b1, 1'b0);
               ring_releases++;
            end
            held_elems.insert(held_elems.size(), e);
         end
         ocs_pkg::CMD_HEADER: begin
            headers_sent++;
            if (chunk_seen != ocs_pkg::SEEN_NONE) begin
               // The stride is fixed once, when the first chunk closes.
               if (chunk_seen == ocs_pkg::SEEN_FIRST)
                  stride = (first_moves != 0) ?
                           ((prior_raw + first_moves / 2) / first_moves) & 32'hFFFF : 0;
               ov = longint'(prior_raw) + prior_off - longint'(off);
               od = (ov > 0 && stride != 0) ? ov / longint'(stride) : 0;
               rear  = od / 2;
               front = od - rear;
               if (rear > held_elems.size()) begin
                  overflow_sticky = 1'b1;
                  rear = held_elems.size();
               end
               keep = held_elems.size() - rear;
               for (int i = 0; i < keep; i++)
                  release_elem(held_elems[i], i == keep - 1, 1'b0);
               head_skip = (front > ocs_pkg::SKIP_MAX) ? ocs_pkg::SKIP_MAX : int'(front);
               chunk_seen = ocs_pkg::SEEN_LATER;
            end else begin
               chunk_seen  = ocs_pkg::SEEN_FIRST;
               head_skip   = 0;
               first_moves = 0;
            end
            prior_raw  = raw;
            prior_off  = off;
            elem_index = 0;
            held_elems.delete();
         end
         ocs_pkg::CMD_FLUSH: begin
            flushes_sent++;
            if (chunk_seen != ocs_pkg::SEEN_NONE)
               foreach (held_elems[i])
                  release_elem(held_elems[i], i == held_elems.size() - 1,
                               i == held_elems.size() - 1);
            // A flush always returns the whole stitcher to its reset state.
            held_elems.delete();
            elem_index      = 0;
            head_skip       = 0;
            prior_raw       = 0;
            prior_off       = 0;
            first_moves     = 0;
            stride          = 0;
            chunk_seen      = ocs_pkg::SEEN_NONE;
            overflow_sticky = 1'b0;
         end
         default: spare_sent++;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus building blocks.
   // ---------------------------------------------------------------------
   task automatic queue_item(input logic [1:0] cmd,
         input logic [ocs_pkg::REQ_DATA_W-1:0] data, input bit drain = 1'b0);
      send_item_type it;
      it.cmd        = cmd;
      it.data       = data;
      it.gap_pct    = cur_gap_pct;
      it.wait_drain = drain;
      send_queue.insert(send_queue.size(), it);
      if (cmd != CMD_SPARE)
         stim_items++;
   endtask

   // Fields that a command does not use are filled at random; the block must
   // not care about them.
   task automatic queue_header(input logic [ocs_pkg::RAW_W-1:0] raw,
         input logic [ocs_pkg::OFFSET_W-1:0] off, input bit drain = 1'b0);
      queue_item(ocs_pkg::CMD_HEADER,
                 pack_fields(raw, off, 1'($urandom), 8'($urandom), 8'($urandom)), drain);
   endtask

   task automatic queue_move(input logic mv, input logic [ocs_pkg::CHAR_W-1:0] base,
         input logic [ocs_pkg::CHAR_W-1:0] qual);
      queue_item(ocs_pkg::CMD_MOVE, pack_fields(16'($urandom), $urandom, mv, base, qual));
   endtask

   task automatic queue_flush();
      queue_item(ocs_pkg::CMD_FLUSH, pack_fields(16'($urandom), $urandom, 1'($urandom),
                                                 8'($urandom), 8'($urandom)));
   endtask

   task automatic queue_random_move();
      queue_move($urandom_range(0, 9) < 7, 8'($urandom), 8'($urandom));
   endtask

   // Stray items that break up a well-formed read.
   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: queue_item(CMD_SPARE, pack_fields(16'($urandom), $urandom, 1'($urandom),
                                              8'($urandom), 8'($urandom)));
         1: queue_header(16'($urandom), $urandom);
         2: queue_flush();
         default: queue_random_move();
      endcase
   endtask

   // One read: a chain of chunks whose offsets overlap by a chosen number of
   // strides, now and then a gap or a huge overlap, and usually a closing flush.
   task automatic queue_random_read(input bit drain);
      int                           s, n, prev_n, chunks, r;
      logic [ocs_pkg::RAW_W-1:0]    raw, prev_raw;
      logic [ocs_pkg::OFFSET_W-1:0] off, prev_off;
      longint                       overlap;
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 800) : $urandom_range(1, 12);
      chunks = $urandom_range(1, 4);
      prev_n = 0;
      prev_raw = '0;
      prev_off = '0;
      off = $urandom;
      for (int c = 0; c < chunks; c++) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 20);
         r = n * s + $urandom_range(0, s - 1);
         raw = (r > 65535) ? 16'hFFFF : 16'(r);
         if (c > 0) begin
            case ($urandom_range(0, 7))
               0: overlap = -longint'($urandom_range(1, 5000));
               1: overlap = longint'($urandom);
               default: overlap = longint'($urandom_range(0, 2 * prev_n + 2)) * s
                                  + $urandom_range(0, s - 1);
            endcase
            off = prev_off + 32'(prev_raw) - 32'(overlap);
         end
         queue_header(raw, off, drain && c == 0);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 39) == 0)
               queue_noise();
            queue_random_move();
         end
         prev_n = n;
         prev_raw = raw;
         prev_off = off;
      end
      // Sometimes the read runs on into the next one without a flush.
      if ($urandom_range(0, 5) != 0)
         queue_flush();
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents one item at a time from send_queue, with random gaps.
   // The next item may follow in the same cycle its predecessor is taken, so
   // req_tvalid gets exactly one assignment per edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            stitch_item(offered);
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
            end else if (send_queue.size() != 0 &&
                         !(send_queue[0].wait_drain && expected_elems.size() != 0)) begin
               if (send_queue.size() >= TAIL_ITEMS && !gap_done &&
                   $urandom_range(0, 99) < send_queue[0].gap_pct) begin
                  // This cycle is the first of the gap.
                  send_gap_left = $urandom_range(1, 6) - 1;
                  gap_done = 1'b1;
               end else begin
                  offered = send_queue.pop_front();
                  offer = 1'b1;
                  gap_done = 1'b0;
                  req_tdata <= offered.data;
                  req_tuser <= offered.cmd;
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stalls rsp_tready in bursts; the stall rate is redrawn by
   // pick_gap_pct and may be zero, so there are stretches with no stalls at all.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count % 256 == 0)
            recv_pct = pick_gap_pct();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (send_queue.size() >= TAIL_ITEMS && $urandom_range(0, 99) < recv_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every element taken from the block is checked against the
   // oldest one still owed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stitched_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_elems.size() == 0) begin
            report_mismatch("element with none expected, tdata", rsp_tdata, 0);
         end else begin
            want = expected_elems.pop_front();
            if (want.ovf)
               overflow_results++;
            if (rsp_tdata[0] !== want.elem.mv)
               report_mismatch("out_move", rsp_tdata[0], want.elem.mv);
            if (rsp_tdata[8:1] !== want.elem.base)
               report_mismatch("out_base", rsp_tdata[8:1], want.elem.base);
            if (rsp_tdata[16:9] !== want.elem.qual)
               report_mismatch("out_qual", rsp_tdata[16:9], want.elem.qual);
            if (rsp_tdata[23:17] !== 7'd0)
               report_mismatch("tdata padding", rsp_tdata[23:17], 0);
            if (rsp_tlast !== want.run_end)
               report_mismatch("run_end", rsp_tlast, want.run_end);
            if (rsp_tuser[0] !== want.read_end)
               report_mismatch("read_end", rsp_tuser[0], want.read_end);
            if (rsp_tuser[1] !== want.ovf)
               report_mismatch("overflow", rsp_tuser[1], want.ovf);
         end
         results_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and the end of the run.
   // ---------------------------------------------------------------------
   initial begin
      int target;

      // Directed part. Before any header a move and a flush do nothing, and
      // the spare command is always ignored.
      cur_gap_pct = 20;
      queue_move(1'b1, 8'hA5, 8'h5A);
      queue_flush();
      queue_item(CMD_SPARE, pack_fields(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF));
      // A first chunk with no elements gives a zero stride, so even this huge
      // overlap trims nothing. A move of 0 must come out with zero characters.
      queue_header(16'hFFFF, 32'hFFFF_FFFF);
      queue_header(16'd100, 32'd0);
      queue_move(1'b1, 8'hFF, 8'hFF);
      queue_move(1'b0, 8'hFF, 8'hFF);
      queue_move(1'b1, 8'h00, 8'h00);
      queue_flush();
      // Flush with nothing held.
      queue_flush();
      // Rounding gives a zero stride: raw size 0 over three elements.
      queue_header(16'd0, 32'd1000);
      repeat (3) queue_move(1'b1, 8'($urandom), 8'($urandom));
      queue_header(16'd50, 32'd900);
      queue_move(1'b1, 8'h47, 8'h21);
      queue_flush();
      // Stride 1 and an overlap of six: the rear half of three exceeds the two
      // held elements, so the overflow flag sets and stays on for the read.
      queue_header(16'd2, 32'h0001_0000);
      queue_move(1'b1, 8'h41, 8'h30);
      queue_move(1'b1, 8'h43, 8'h31);
      queue_header(16'd4, 32'h0000_FFFC);
      repeat (5) queue_move(1'b1, 8'($urandom), 8'($urandom));
      queue_flush();

      // First random stretch. The first read of every four waits until the
      // block has handed back everything it owes.
      target = stim_items + 100;
      for (int rd = 0; stim_items < target; rd++) begin
         cur_gap_pct = pick_gap_pct();
         queue_random_read(rd % 4 == 0);
      end

      // One long first chunk: the ring releases on every element past its
      // depth. Its stride is 936, and the next header overlaps by ten strides,
      // so five elements come off the held tail and five off the new head.
      cur_gap_pct = 3;
      queue_header(16'hFFFF, 32'h1000_0000, 1'b1);
      repeat (LONG_CHUNK_MOVES) queue_random_move();
      queue_header(16'($urandom_range(50, 200)), 32'h1000_0000 + 32'hFFFF - 32'd9365);
      repeat (30) queue_random_move();
      queue_flush();

      // Second random stretch; its tail runs without any idling.
      target = stim_items + 50;
      for (int rd = 0; stim_items < target; rd++) begin
         cur_gap_pct = pick_gap_pct();
         queue_random_read(rd % 4 == 0);
      end
      queue_flush();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_elems.size() != 0)
         @(posedge clock);
      // Anything the block emits from here on is caught by the monitor.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d headers, %0d moves, %0d flushes and %0d spare commands.",
               headers_sent, moves_sent, flushes_sent, spare_sent);
      $display("Checked %0d elements: %0d with overflow, %0d ring releases, %0d mismatches.",
               results_checked, overflow_results, ring_releases, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, sized well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Timeout with %0d items unsent and %0d elements still owed.",
               send_queue.size(), expected_elems.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
